// ===== rtl/external_interrupt_controller_unit_assert.svh =====
// Assertion macros for the controller file that checks itself with them.
`ifndef EXTERNAL_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH
`define EXTERNAL_INTERRUPT_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EICU_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EICU_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/eicu_pkg.sv =====
package eicu_pkg;

  localparam int NUM_PINS       = 192;
  localparam int NUM_PORTS      = 6;
  localparam int REG_WORDS      = 1024;
  localparam int BYTES_PER_WORD = 4;

  localparam int PIN_WORDS  = (NUM_PINS + 31) / 32;
  localparam int ADDR_W     = $clog2(REG_WORDS);
  localparam int WADDR_W    = 10;
  localparam int PIN_W      = 8;
  localparam int BIT_W      = 5;
  localparam int WIN_SHIFT  = 4;
  localparam int PORT_W     = WIN_SHIFT;
  localparam int WIN_W      = WADDR_W - WIN_SHIFT;
  localparam int PIN_IDX_W  = (PIN_WORDS > 1) ? $clog2(PIN_WORDS) : 1;
  localparam int PEND_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [WADDR_W-1:0] W_STAT     = WADDR_W'('h000 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_ACK      = WADDR_W'('h040 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_MASK     = WADDR_W'('h080 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_MASK_SET = WADDR_W'('h0c0 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_MASK_CLR = WADDR_W'('h100 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_SENS     = WADDR_W'('h140 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_SENS_SET = WADDR_W'('h180 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_SENS_CLR = WADDR_W'('h1c0 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_SOFT     = WADDR_W'('h200 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_SOFT_SET = WADDR_W'('h240 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_SOFT_CLR = WADDR_W'('h280 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_POL      = WADDR_W'('h300 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_POL_SET  = WADDR_W'('h340 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_POL_CLR  = WADDR_W'('h380 / BYTES_PER_WORD);
  localparam logic [WADDR_W-1:0] W_DOM_EN   = WADDR_W'('h400 / BYTES_PER_WORD);

  localparam logic [WIN_W-1:0] WIN_STAT     = W_STAT[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_ACK      = W_ACK[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_MASK     = W_MASK[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_MASK_SET = W_MASK_SET[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_MASK_CLR = W_MASK_CLR[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_SENS     = W_SENS[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_SENS_SET = W_SENS_SET[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_SENS_CLR = W_SENS_CLR[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_SOFT     = W_SOFT[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_SOFT_SET = W_SOFT_SET[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_SOFT_CLR = W_SOFT_CLR[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_POL      = W_POL[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_POL_SET  = W_POL_SET[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_POL_CLR  = W_POL_CLR[WADDR_W-1:WIN_SHIFT];
  localparam logic [WIN_W-1:0] WIN_DOM_EN   = W_DOM_EN[WADDR_W-1:WIN_SHIFT];

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_PIN
  } kind_t;

  typedef enum logic [2:0] {
    BASE_STAT,
    BASE_MASK,
    BASE_SENS,
    BASE_SOFT,
    BASE_POL,
    BASE_DOM
  } base_t;

  typedef enum logic [1:0] {
    ACT_WR,
    ACT_SET,
    ACT_CLR
  } act_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [WADDR_W-1:0] word_addr;
    logic [31:0]        write_data;
    logic [PIN_W-1:0]   pin;
    logic               level;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } out_word_t;

  typedef struct packed {
    logic              hit;
    base_t             base;
    act_t              act;
    logic [PORT_W-1:0] port;
  } dec_t;

  typedef struct packed {
    logic             is_pin;
    base_t            base;
    act_t             act;
    logic [31:0]      data;
    logic             level;
    logic [BIT_W-1:0] pin_bit;
    logic [31:0]      stat;
    logic [31:0]      mask;
    logic [31:0]      dom;
    logic [31:0]      sens;
    logic [31:0]      pol;
    logic [31:0]      tgt;
    logic [31:0]      lv;
    logic [31:0]      pin_ok;
  } calc_in_t;

  typedef struct packed {
    logic        tgt_we;
    logic [31:0] tgt_val;
    logic [31:0] stat_val;
    logic [31:0] lv_val;
    logic        pend;
  } calc_out_t;

  function automatic dec_t decode_addr(input logic [WADDR_W-1:0] addr);
    dec_t d;
    logic known;
    d.port = addr[WIN_SHIFT-1:0];
    d.base = BASE_STAT;
    d.act  = ACT_WR;
    known  = 1'b1;
    case (addr[WADDR_W-1:WIN_SHIFT])
      WIN_STAT: begin
        d.act = ACT_WR;
      end
      WIN_ACK: begin
        d.act = ACT_CLR;
      end
      WIN_MASK: begin
        d.base = BASE_MASK;
      end
      WIN_MASK_SET: begin
        d.base = BASE_MASK;
        d.act  = ACT_SET;
      end
      WIN_MASK_CLR: begin
        d.base = BASE_MASK;
        d.act  = ACT_CLR;
      end
      WIN_SENS: begin
        d.base = BASE_SENS;
      end
      WIN_SENS_SET: begin
        d.base = BASE_SENS;
        d.act  = ACT_SET;
      end
      WIN_SENS_CLR: begin
        d.base = BASE_SENS;
        d.act  = ACT_CLR;
      end
      WIN_SOFT: begin
        d.base = BASE_SOFT;
      end
      WIN_SOFT_SET: begin
        d.base = BASE_SOFT;
        d.act  = ACT_SET;
      end
      WIN_SOFT_CLR: begin
        d.base = BASE_SOFT;
        d.act  = ACT_CLR;
      end
      WIN_POL: begin
        d.base = BASE_POL;
      end
      WIN_POL_SET: begin
        d.base = BASE_POL;
        d.act  = ACT_SET;
      end
      WIN_POL_CLR: begin
        d.base = BASE_POL;
        d.act  = ACT_CLR;
      end
      WIN_DOM_EN: begin
        d.base = BASE_DOM;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    d.hit = known && (int'(d.port) < NUM_PORTS);
    return d;
  endfunction

  function automatic logic [WIN_W-1:0] base_win(input base_t b);
    logic [WIN_W-1:0] w;
    case (b)
      BASE_MASK: w = WIN_MASK;
      BASE_SENS: w = WIN_SENS;
      BASE_SOFT: w = WIN_SOFT;
      BASE_POL:  w = WIN_POL;
      BASE_DOM:  w = WIN_DOM_EN;
      default:   w = WIN_STAT;
    endcase
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] word_of(input logic [WIN_W-1:0] win,
                                                 input logic [PORT_W-1:0] port);
    return ADDR_W'({win, port});
  endfunction

  function automatic logic [31:0] pin_mask(input logic [PORT_W-1:0] port);
    logic [31:0] m;
    for (int b = 0; b < 32; b++) begin
      m[b] = (int'(port) * 32 + b) < NUM_PINS;
    end
    return m;
  endfunction

  function automatic logic [31:0] rst_value(input logic [ADDR_W-1:0] a);
    logic in_mask;
    in_mask = (int'(a) >= int'(W_MASK)) && (int'(a) < int'(W_MASK) + NUM_PORTS);
    return in_mask ? ALL_ONES : 32'h0;
  endfunction

endpackage

// ===== rtl/eicu_ram.sv =====
module eicu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/eicu_update.sv =====
module eicu_update import eicu_pkg::*; (
  input  calc_in_t  ci,
  output calc_out_t co
);

  logic [31:0] tgt_new;
  logic [31:0] bit_m;
  logic [31:0] latch_m;
  logic [31:0] stat_new;
  logic [31:0] mask_new;
  logic [31:0] dom_new;
  logic [31:0] lv_new;
  logic        tgt_we;
  logic        old_lv;
  logic        pol_b;
  logic        sens_b;

  always_comb begin
    case (ci.act)
      ACT_SET: tgt_new = ci.tgt | ci.data;
      ACT_CLR: tgt_new = ci.tgt & ~ci.data;
      default: tgt_new = ci.data;
    endcase
  end

  assign bit_m  = 32'(1) << ci.pin_bit;
  assign old_lv = |(ci.lv & bit_m);
  assign pol_b  = |(ci.pol & bit_m);
  assign sens_b = |(ci.sens & bit_m);

  // Level-sensitive pins that exist and sit at their polarity latch on a mask clear.
  assign latch_m = ci.data & ci.sens & ~(ci.lv ^ ci.pol) & ci.pin_ok;

  always_comb begin
    tgt_we   = 1'b0;
    stat_new = ci.stat;
    mask_new = ci.mask;
    dom_new  = ci.dom;
    lv_new   = ci.lv;
    if (ci.is_pin) begin
      lv_new = ci.level ? (ci.lv | bit_m) : (ci.lv & ~bit_m);
      if ((ci.level == pol_b) && (sens_b || (old_lv != ci.level))) begin
        stat_new = ci.stat | bit_m;
      end
    end else begin
      case (ci.base)
        BASE_STAT: begin
          stat_new = tgt_new;
        end
        BASE_MASK: begin
          tgt_we   = 1'b1;
          mask_new = tgt_new;
          if (ci.act == ACT_CLR) begin
            stat_new = ci.stat | latch_m;
          end
        end
        BASE_SOFT: begin
          tgt_we   = 1'b1;
          stat_new = (ci.act == ACT_CLR) ? (ci.stat & ~ci.data) : (ci.stat | ci.data);
        end
        BASE_DOM: begin
          tgt_we  = 1'b1;
          dom_new = tgt_new;
        end
        default: begin
          tgt_we = 1'b1;
        end
      endcase
    end
  end

  assign co.tgt_we   = tgt_we;
  assign co.tgt_val  = tgt_new;
  assign co.stat_val = stat_new;
  assign co.lv_val   = lv_new;
  assign co.pend     = |(stat_new & ~mask_new & dom_new);

endmodule

// ===== rtl/external_interrupt_controller_unit.sv =====
// Reads, writes outside the port windows, ignored pins and unused kinds go straight to ST_FIN,
// where the output word is loaded once the output is free; no new word is taken meanwhile.
// Port-window writes and pin changes: reads of the status/mask, domain/sensitivity and
// polarity/target words on the dual-read register store, an update and a status write-back.
// Reset is synchronous; afterwards the store is swept one word per cycle through all REG_WORDS
// (1024) words while in_stall stays high.
`include "external_interrupt_controller_unit_assert.svh"

module external_interrupt_controller_unit import eicu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  state_t             state_r;
  state_t             state_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               clr_last;
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               out_valid_r;
  out_word_t          out_word_r;
  logic [NUM_PORTS-1:0] pending_r;
  logic [31:0]        pin_levels_r [PIN_WORDS];

  dec_t               dec_in;
  logic               addr_ok_in;
  logic               is_pin_in;
  logic               port_item_in;
  logic               gen_wr_in;
  logic [PORT_W-1:0]  port_in;
  base_t              base_in;

  logic [31:0]        data_r;
  logic               level_r;
  logic [BIT_W-1:0]   pin_bit_r;
  logic [PORT_W-1:0]  port_r;
  base_t              base_r;
  act_t               act_r;
  logic               is_pin_r;
  logic               port_item_r;
  logic               rd_ok_r;
  logic [31:0]        stat_r;
  logic [31:0]        mask_r;
  logic [31:0]        dom_r;
  logic [31:0]        sens_r;
  logic [31:0]        stat_new_r;
  logic [31:0]        lv_cur;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr_a;
  logic [ADDR_W-1:0]  ram_raddr_b;
  logic [31:0]        ram_rdata_a;
  logic [31:0]        ram_rdata_b;

  calc_in_t           ci;
  calc_out_t          co;

  eicu_ram #(
    .WIDTH (32),
    .DEPTH (REG_WORDS)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  eicu_update u_update (
    .ci (ci),
    .co (co)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign clr_last  = (clr_cnt_r == ADDR_W'(REG_WORDS - 1));

  assign dec_in       = decode_addr(in_word.word_addr);
  assign addr_ok_in   = int'(in_word.word_addr) < REG_WORDS;
  assign is_pin_in    = (in_word.kind == KIND_PIN) && (int'(in_word.pin) < NUM_PINS);
  assign port_item_in = ((in_word.kind == KIND_WRITE) && dec_in.hit) || is_pin_in;
  assign gen_wr_in    = (in_word.kind == KIND_WRITE) && !dec_in.hit && addr_ok_in;
  assign port_in      = is_pin_in ? PORT_W'(in_word.pin[PIN_W-1:BIT_W]) : dec_in.port;
  assign base_in      = is_pin_in ? BASE_STAT : dec_in.base;

  assign lv_cur = (int'(port_r) < PIN_WORDS) ? pin_levels_r[port_r[PIN_IDX_W-1:0]] : 32'h0;

  always_comb begin
    ci.is_pin  = is_pin_r;
    ci.base    = base_r;
    ci.act     = act_r;
    ci.data    = data_r;
    ci.level   = level_r;
    ci.pin_bit = pin_bit_r;
    ci.stat    = stat_r;
    ci.mask    = mask_r;
    ci.dom     = dom_r;
    ci.sens    = sens_r;
    ci.pol     = ram_rdata_a;
    ci.tgt     = ram_rdata_b;
    ci.lv      = lv_cur;
    ci.pin_ok  = pin_mask(port_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = port_item_in ? ST_RD1 : ST_FIN;
        end
      end
      ST_RD1: begin
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_r;
    ram_wdata   = rst_value(clr_cnt_r);
    ram_re      = 1'b0;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    out_load    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (port_item_in) begin
            ram_re      = 1'b1;
            ram_raddr_a = word_of(WIN_STAT, port_in);
            ram_raddr_b = word_of(WIN_MASK, port_in);
          end else if (in_word.kind == KIND_READ) begin
            ram_re      = 1'b1;
            ram_raddr_a = ADDR_W'(in_word.word_addr);
          end
          if (gen_wr_in) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(in_word.word_addr);
            ram_wdata = in_word.write_data;
          end
        end
      end
      ST_RD1: begin
        ram_re      = 1'b1;
        ram_raddr_a = word_of(WIN_DOM_EN, port_r);
        ram_raddr_b = word_of(WIN_SENS, port_r);
      end
      ST_RD2: begin
        ram_re      = 1'b1;
        ram_raddr_a = word_of(WIN_POL, port_r);
        ram_raddr_b = word_of(base_win(base_r), port_r);
      end
      ST_CALC: begin
        ram_we    = co.tgt_we;
        ram_waddr = word_of(base_win(base_r), port_r);
        ram_wdata = co.tgt_val;
      end
      ST_FIN: begin
        ram_we    = port_item_r;
        ram_waddr = word_of(WIN_STAT, port_r);
        ram_wdata = stat_new_r;
        out_load  = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pending_r   <= '0;
      for (int i = 0; i < PIN_WORDS; i++) begin
        pin_levels_r[i] <= ALL_ONES;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if ((state_r == ST_CALC) && (int'(port_r) < NUM_PORTS)) begin
        pending_r[port_r[PEND_IDX_W-1:0]] <= co.pend;
      end
      if ((state_r == ST_CALC) && is_pin_r) begin
        pin_levels_r[port_r[PIN_IDX_W-1:0]] <= co.lv_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r      <= in_word.write_data;
      level_r     <= in_word.level;
      pin_bit_r   <= in_word.pin[BIT_W-1:0];
      port_r      <= port_in;
      base_r      <= base_in;
      act_r       <= dec_in.act;
      is_pin_r    <= is_pin_in;
      port_item_r <= port_item_in;
      rd_ok_r     <= (in_word.kind == KIND_READ) && addr_ok_in;
    end
    if (state_r == ST_RD1) begin
      stat_r <= ram_rdata_a;
      mask_r <= ram_rdata_b;
    end
    if (state_r == ST_RD2) begin
      dom_r  <= ram_rdata_a;
      sens_r <= ram_rdata_b;
    end
    if (state_r == ST_CALC) begin
      stat_new_r <= co.stat_val;
    end
    if (out_load) begin
      out_word_r.read_data <= rd_ok_r ? ram_rdata_a : 32'h0;
      out_word_r.irq       <= |pending_r;
    end
  end

  `EICU_CHECK_NEXT(a_rd_sequence, state_r == ST_RD1, state_r == ST_RD2, "Read phase broke off.")
  `EICU_CHECK_NEXT(a_pending_hold, state_r != ST_CALC, $stable(pending_r), "Pending changed.")
  `EICU_CHECK_NOW(a_out_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN, "Early word.")
  `EICU_CHECK_NEXT(a_irq_match, out_load, out_word_r.irq == (|pending_r), "Irq mismatch.")

endmodule

// ===== tb/external_interrupt_controller_unit_tb.sv =====
`timescale 1ns / 1ps

module external_interrupt_controller_unit_tb;
  import eicu_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 600;

  class eint_scoreboard;
    logic [31:0] regs [REG_WORDS];
    logic [31:0] levels [PIN_WORDS];
    out_word_t owed_results [$];
    int failures;

    function new();
      int i;
      for (i = 0; i < REG_WORDS; i++) regs[i] = 32'h0;
      for (i = 0; i < NUM_PORTS; i++) regs[W_MASK + i] = ALL_ONES;
      for (i = 0; i < PIN_WORDS; i++) levels[i] = ALL_ONES;
      failures = 0;
    endfunction

    function logic [31:0] read_word(int a);
      return (a < REG_WORDS) ? regs[a] : 32'h0;
    endfunction

    function bit in_port_window(int a, int base, output int p);
      p = a - base;
      return (a >= base) && (a < base + NUM_PORTS);
    endfunction

    function void unmask_latch(int p, logic [31:0] bits);
      int b;
      logic lv;
      bits &= regs[W_SENS + p];
      for (b = 0; b < 32; b++) begin
        lv = (p < PIN_WORDS) ? levels[p][b] : 1'b0;
        if (bits[b] && (p * 32 + b) < NUM_PINS && lv == regs[W_POL + p][b])
          regs[W_STAT + p][b] = 1'b1;
      end
    endfunction

    function void bus_write(int a, logic [31:0] v);
      int p;
      if (in_port_window(a, W_ACK, p)) regs[W_STAT + p] &= ~v;
      else if (in_port_window(a, W_MASK, p)) regs[W_MASK + p] = v;
      else if (in_port_window(a, W_MASK_SET, p)) regs[W_MASK + p] |= v;
      else if (in_port_window(a, W_MASK_CLR, p)) begin
        regs[W_MASK + p] &= ~v;
        unmask_latch(p, v);
      end
      else if (in_port_window(a, W_SENS, p)) regs[W_SENS + p] = v;
      else if (in_port_window(a, W_SENS_SET, p)) regs[W_SENS + p] |= v;
      else if (in_port_window(a, W_SENS_CLR, p)) regs[W_SENS + p] &= ~v;
      else if (in_port_window(a, W_SOFT, p)) begin
        regs[W_SOFT + p] = v;
        regs[W_STAT + p] |= v;
      end
      else if (in_port_window(a, W_SOFT_SET, p)) begin
        regs[W_SOFT + p] |= v;
        regs[W_STAT + p] |= v;
      end
      else if (in_port_window(a, W_SOFT_CLR, p)) begin
        regs[W_SOFT + p] &= ~v;
        regs[W_STAT + p] &= ~v;
      end
      else if (in_port_window(a, W_POL, p)) regs[W_POL + p] = v;
      else if (in_port_window(a, W_POL_SET, p)) regs[W_POL + p] |= v;
      else if (in_port_window(a, W_POL_CLR, p)) regs[W_POL + p] &= ~v;
      else if (in_port_window(a, W_DOM_EN, p)) regs[W_DOM_EN + p] = v;
      else if (a < REG_WORDS) regs[a] = v;
    endfunction

    function void pin_change(int pin, logic lvl);
      int port;
      int b;
      logic old;
      logic pol;
      logic sens;
      if (pin >= NUM_PINS) return;
      port = pin / 32;
      b = pin % 32;
      old = levels[port][b];
      levels[port][b] = lvl;
      pol = regs[W_POL + port][b];
      sens = regs[W_SENS + port][b];
      if (lvl == pol && (sens || old != lvl)) regs[W_STAT + port][b] = 1'b1;
    endfunction

    function logic irq_line();
      int p;
      logic any;
      any = 1'b0;
      for (p = 0; p < NUM_PORTS; p++)
        any |= |(regs[W_STAT + p] & ~regs[W_MASK + p] & regs[W_DOM_EN + p]);
      return any;
    endfunction

    function void note_item(in_word_t w);
      out_word_t r;
      r.read_data = 32'h0;
      case (w.kind)
        KIND_READ: r.read_data = read_word(w.word_addr);
        KIND_WRITE: bus_write(w.word_addr, w.write_data);
        KIND_PIN: pin_change(w.pin, w.level);
        default: ;
      endcase
      r.irq = irq_line();
      owed_results.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (owed_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result word: read_data=%h irq=%b", got.read_data, got.irq);
        return;
      end
      want = owed_results.pop_front();
      if (got.read_data !== want.read_data || got.irq !== want.irq) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected read_data=%h irq=%b, got read_data=%h irq=%b",
                   want.read_data, want.irq, got.read_data, got.irq);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  eint_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;

  logic [WADDR_W-1:0] window_base [15] = '{
    W_STAT, W_ACK, W_MASK, W_MASK_SET, W_MASK_CLR, W_SENS, W_SENS_SET, W_SENS_CLR,
    W_SOFT, W_SOFT_SET, W_SOFT_CLR, W_POL, W_POL_SET, W_POL_CLR, W_DOM_EN
  };

  external_interrupt_controller_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic push_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(w);
  endtask

  function automatic in_word_t filler_word();
    in_word_t w;
    w.kind = KIND_READ;
    w.word_addr = WADDR_W'($urandom);
    w.write_data = $urandom;
    w.pin = PIN_W'($urandom);
    w.level = 1'($urandom);
    return w;
  endfunction

  task automatic do_read(input int a);
    in_word_t w;
    w = filler_word();
    w.word_addr = WADDR_W'(a);
    push_word(w);
  endtask

  task automatic do_write(input int a, input logic [31:0] d);
    in_word_t w;
    w = filler_word();
    w.kind = KIND_WRITE;
    w.word_addr = WADDR_W'(a);
    w.write_data = d;
    push_word(w);
  endtask

  task automatic do_pin(input int pin, input logic lvl);
    in_word_t w;
    w = filler_word();
    w.kind = KIND_PIN;
    w.pin = PIN_W'(pin);
    w.level = lvl;
    push_word(w);
  endtask

  function automatic logic [31:0] random_data();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return ALL_ONES;
      2: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t random_item();
    in_word_t w;
    int roll;
    int port;
    int win;
    w = filler_word();
    roll = $urandom_range(99);
    port = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(NUM_PORTS - 1);
    win = $urandom_range(14);
    if (roll < 35) begin
      w.kind = KIND_PIN;
      w.pin = PIN_W'(($urandom_range(9) == 0) ? $urandom_range(255, NUM_PINS)
                                              : $urandom_range(NUM_PINS - 1));
    end else if (roll < 72) begin
      w.kind = KIND_WRITE;
      w.word_addr = WADDR_W'(int'(window_base[win]) + port);
      w.write_data = random_data();
    end else if (roll < 90) begin
      w.kind = KIND_READ;
      if ($urandom_range(3) != 0) w.word_addr = WADDR_W'(int'(window_base[win]) + port);
    end else if (roll < 98) begin
      w.kind = KIND_WRITE;
      w.write_data = random_data();
    end else begin
      w.kind = KIND_UNUSED;
    end
    return w;
  endfunction

  task automatic directed_items();
    in_word_t w;
    do_read(W_MASK);
    do_read(0);
    do_write(W_DOM_EN, ALL_ONES);
    do_write(W_MASK_CLR, ALL_ONES);
    do_pin(0, 1'b0);
    do_write(W_ACK, ALL_ONES);
    do_read(W_ACK);
    do_write(W_SENS_SET + 1, 32'h8000_0000);
    do_write(W_POL_SET + 1, ALL_ONES);
    do_write(W_DOM_EN + 1, ALL_ONES);
    // A level-sensitive pin already at its polarity latches when it is unmasked.
    do_write(W_MASK_CLR + 1, 32'h8000_0001);
    do_read(W_STAT + 1);
    do_write(W_POL_CLR + 1, ALL_ONES);
    do_write(W_SENS_CLR + 1, ALL_ONES);
    do_write(W_SOFT + 2, 32'h0000_00ff);
    do_write(W_SOFT_SET + 2, 32'hff00_0000);
    do_write(W_SOFT_CLR + 2, ALL_ONES);
    do_write(W_MASK_SET + 1, ALL_ONES);
    do_pin(NUM_PINS, 1'b0);
    do_pin(255, 1'b1);
    w = filler_word();
    w.kind = KIND_UNUSED;
    push_word(w);
    do_write(REG_WORDS - 1, ALL_ONES);
    do_read(REG_WORDS - 1);
    do_write(W_STAT + 5, 32'h1234_5678);
    do_write(W_DOM_EN + 5, ALL_ONES);
    do_write(W_MASK + 5, 32'h0);
    do_write(W_MASK + 10, 32'hdead_beef);
    do_read(W_MASK + 10);
    do_write(W_SENS + 3, ALL_ONES);
    do_write(W_POL + 3, 32'h0);
    do_pin(NUM_PINS - 1, 1'b0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_word);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("[external_interrupt_controller_unit] ERROR");
    $finish;
  end

  initial begin
    int phase;
    int n;
    board = new();
    send_idle_pct = 20;
    recv_idle_pct = 86;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 20 : 0;
      for (n = 0; n < RANDOM_PER_PHASE; n++) push_word(random_item());
    end
    in_valid <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.failures == 0) begin
      $display("[external_interrupt_controller_unit] OK");
    end else begin
      $display("[external_interrupt_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== external_interrupt_controller_unit.f =====
+incdir+rtl
rtl/eicu_pkg.sv
rtl/eicu_ram.sv
rtl/eicu_update.sv
rtl/external_interrupt_controller_unit.sv
tb/external_interrupt_controller_unit_tb.sv
